@@ rtl/pbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbps_pkg
// Shared types, constants and pattern tables of the beep pattern sequencer.
// ----------------------------------------------------------------------------
package pbps_pkg;

    localparam int TICK_W = 16;
    localparam int PRIO_W = 4;
    localparam int REP_W  = 2;
    localparam int PAT_W  = 2;
    localparam int NUM_PAT = 4;
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IDX_W = 3;

    // item kinds carried in tuser
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [PAT_W-1:0] {
        PAT_BRIEF   = 2'd0,
        PAT_CONFIRM = 2'd1,
        PAT_WARNING = 2'd2,
        PAT_ALERT   = 2'd3
    } t_pattern;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ON     = 2'd1,
        PH_SILENT = 2'd2
    } t_phase;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BRIEF_ON      = 3'd0,
        REG_CONFIRM_ON    = 3'd1,
        REG_WARNING_ON    = 3'd2,
        REG_ALERT_ON      = 3'd3,
        REG_BRIEF_PRIO    = 3'd4,
        REG_CONFIRM_PRIO  = 3'd5,
        REG_WARNING_PRIO  = 3'd6,
        REG_ALERT_PRIO    = 3'd7
    } t_reg_idx;

    localparam logic [TICK_W-1:0] ON_RST [NUM_PAT] = '{16'd50, 16'd100, 16'd200, 16'd300};
    localparam logic [PRIO_W-1:0] PRIO_RST [NUM_PAT] = '{4'd1, 4'd2, 4'd3, 4'd4};

    localparam logic [TICK_W-1:0] WARNING_SILENCE = 16'd200;
    localparam logic [TICK_W-1:0] ALERT_SILENCE   = 16'd300;
    localparam logic [REP_W-1:0]  WARNING_REPEATS = 2'd2;
    localparam logic [REP_W-1:0]  ALERT_REPEATS   = 2'd3;

    typedef struct packed {
        logic [NUM_PAT-1:0][TICK_W-1:0] on_len;
        logic [NUM_PAT-1:0][PRIO_W-1:0] prio;
    } t_cfg;

    typedef struct packed {
        logic buzzer_on;
        logic busy_res;
    } t_result;

    function automatic logic [TICK_W-1:0] silence_len(input logic [PAT_W-1:0] pat);
        logic [TICK_W-1:0] len;
        case (t_pattern'(pat))
            PAT_WARNING: len = WARNING_SILENCE;
            PAT_ALERT:   len = ALERT_SILENCE;
            default:     len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [REP_W-1:0] repeat_len(input logic [PAT_W-1:0] pat);
        logic [REP_W-1:0] cnt;
        case (t_pattern'(pat))
            PAT_WARNING: cnt = WARNING_REPEATS;
            PAT_ALERT:   cnt = ALERT_REPEATS;
            default:     cnt = 2'd1;
        endcase
        return cnt;
    endfunction

endpackage

@@ rtl/pbps_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbps_cfg_regs
// APB register file holding on times and priorities of the four patterns.
// ----------------------------------------------------------------------------
module pbps_cfg_regs
    import pbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [NUM_PAT-1:0][TICK_W-1:0] r_on_len;
    logic [NUM_PAT-1:0][PRIO_W-1:0] r_prio;
    logic [REG_IDX_W-1:0]           w_idx;
    logic                           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAT; i++) begin
                r_on_len[i] <= ON_RST[i];
                r_prio[i]   <= PRIO_RST[i];
            end
        end else if (w_wr) begin
            // msb of the index picks the priority bank
            if (!w_idx[REG_IDX_W-1]) begin
                r_on_len[w_idx[PAT_W-1:0]] <= pwdata[TICK_W-1:0];
            end else begin
                r_prio[w_idx[PAT_W-1:0]] <= pwdata[PRIO_W-1:0];
            end
        end
    end

    always_comb begin
        case (t_reg_idx'(w_idx))
            REG_BRIEF_ON, REG_CONFIRM_ON, REG_WARNING_ON, REG_ALERT_ON: begin
                prdata = {{(APB_DW-TICK_W){1'b0}}, r_on_len[w_idx[PAT_W-1:0]]};
            end
            REG_BRIEF_PRIO, REG_CONFIRM_PRIO, REG_WARNING_PRIO, REG_ALERT_PRIO: begin
                prdata = {{(APB_DW-PRIO_W){1'b0}}, r_prio[w_idx[PAT_W-1:0]]};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.on_len = r_on_len;
    assign o_cfg.prio   = r_prio;

endmodule

@@ rtl/pbps_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbps_core
// Pattern state and the single-pass next-state logic for one word.
// ----------------------------------------------------------------------------
module pbps_core
    import pbps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_func,
    input  logic [PAT_W-1:0] i_sel,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic [REP_W-1:0]    r_reps, n_reps;
    logic [PAT_W-1:0]    r_pat, n_pat;

    logic                w_busy;
    logic [TICK_W-1:0]   w_inc;
    logic [REP_W-1:0]    w_rep_dec;
    logic [TICK_W-1:0]   w_sil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_reps  <= '0;
            r_pat   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_reps  <= n_reps;
            r_pat   <= n_pat;
        end
    end

    always_comb begin
        w_busy    = (r_phase == PH_ON) || (r_phase == PH_SILENT);
        w_inc     = (r_ticks != '1) ? r_ticks + 1'b1 : r_ticks;
        w_rep_dec = (r_reps != '0) ? r_reps - 1'b1 : r_reps;
        w_sil     = silence_len(r_pat);

        n_phase = r_phase;
        n_ticks = r_ticks;
        n_reps  = r_reps;
        n_pat   = r_pat;

        if (i_func == FUNC_REQUEST) begin
            if (!w_busy || (i_cfg.prio[i_sel] > i_cfg.prio[r_pat])) begin
                n_pat   = i_sel;
                n_reps  = repeat_len(i_sel);
                n_phase = PH_ON;
                n_ticks = '0;
            end
        end else begin
            case (r_phase)
                PH_ON: begin
                    n_ticks = w_inc;
                    if (w_inc >= i_cfg.on_len[r_pat]) begin
                        n_reps = w_rep_dec;
                        if ((w_rep_dec != '0) && (w_sil != '0)) begin
                            n_phase = PH_SILENT;
                            n_ticks = '0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_SILENT: begin
                    n_ticks = w_inc;
                    if (w_inc >= w_sil) begin
                        n_phase = PH_ON;
                        n_ticks = '0;
                    end
                end
                default: begin
                    // idle: ticks change nothing
                end
            endcase
        end

        o_result.buzzer_on = (n_phase == PH_ON);
        o_result.busy_res  = (n_phase == PH_ON) || (n_phase == PH_SILENT);
    end

endmodule

@@ rtl/priority_beep_pattern_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Path: an accepted input word goes into the input register, then next-state logic
// writes its result into the result register once that register is free or draining.
// Throughput: one word per cycle; the input side keeps taking words while a
// result waits, until both the input and result registers are full.
// Reset: synchronous active low; state goes idle, registers to their defaults.
// ----------------------------------------------------------------------------
// priority_beep_pattern_sequencer_unit
// Buzzer pattern sequencer with priority preemption and APB configuration.
// ----------------------------------------------------------------------------
module priority_beep_pattern_sequencer_unit
    import pbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [1:0] pattern_sel, [7:2] zero
    input  logic              s_tuser,    // [0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,    // [0] buzzer_on, [1] busy_res, [7:2] zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg              w_cfg;
    t_result           w_result;
    logic              w_step;

    logic              r_in_valid;
    logic              r_in_func;
    logic [PAT_W-1:0]  r_in_sel;
    logic              r_out_valid;
    t_result           r_out;

    pbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pbps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_func   (r_in_func),
        .i_sel    (r_in_sel),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // the input word moves on when the result register is free or draining
    assign w_step   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_func <= s_tuser;
            r_in_sel  <= s_tdata[PAT_W-1:0];
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'b0, r_out.busy_res, r_out.buzzer_on};

endmodule

@@ rtl/pbps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbps_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pbps_checker
    import pbps_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [7:0]        m_tdata,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // the buzzer sounds only while a pattern plays
    a_buzz_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
        else $error("buzzer on while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // on-time register reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[APB_AW-1])
        ##1 (psel && !pwrite && (paddr == $past(paddr)))
        |-> (prdata == {{(APB_DW-TICK_W){1'b0}}, $past(pwdata[TICK_W-1:0])}))
        else $error("on-time register readback mismatch");

endmodule

bind priority_beep_pattern_sequencer_unit pbps_checker u_pbps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

@@ test/tb_priority_beep_pattern_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_beep_pattern_sequencer_unit
// Self-checking bench for the beep pattern sequencer. Tick and request words
// go in on the slave stream, and a behavioral model of the sequencer predicts
// the buzzer and busy levels of every result word on the master stream.
// Directed cases cover idle ticks, zero and maximum on times, preemption,
// ignored requests and live priority changes. Random phases then vary the
// registers and the idling on both stream sides. Registers are written and
// read back over APB while the stream is drained.
// ----------------------------------------------------------------------------
module tb_priority_beep_pattern_sequencer_unit;
    import pbps_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 20;
    localparam int BUZZER_BIT     = 0;
    localparam int BUSY_BIT       = 1;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;    // [1:0] pattern_sel, [7:2] zero
    logic              s_tuser  = 1'b0;  // [0] func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;          // [0] buzzer_on, [1] busy_res, [7:2] zero
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    priority_beep_pattern_sequencer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // sequencer model state and register copy
    t_phase            beep_phase = PH_IDLE;
    logic [TICK_W-1:0] beep_ticks = '0;
    logic [REP_W-1:0]  beeps_left = '0;
    t_pattern          cur_pat    = PAT_BRIEF;
    logic [TICK_W-1:0] on_time [NUM_PAT] = '{16'd50, 16'd100, 16'd200, 16'd300};
    logic [PRIO_W-1:0] rank [NUM_PAT]    = '{4'd1, 4'd2, 4'd3, 4'd4};
    logic [TICK_W-1:0] gap_ticks [NUM_PAT] =
        '{16'd0, 16'd0, WARNING_SILENCE, ALERT_SILENCE};
    logic [REP_W-1:0]  beep_total [NUM_PAT] =
        '{2'd1, 2'd1, WARNING_REPEATS, ALERT_REPEATS};

    t_result expected_levels [$];
    t_result level_due;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int n_mismatch   = 0;
    int n_words      = 0;
    int n_results    = 0;
    int n_restarts   = 0;
    int n_rebeeps    = 0;
    int n_reg_writes = 0;

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch %s: expected %0h got %0h (result %0d)", what, exp_v, got_v,
                 n_results);
        n_mismatch++;
    endtask

    function automatic t_pattern rand_pat();
        return t_pattern'($urandom_range(0, 3));
    endfunction

    // one accepted word through the sequencer model
    task automatic advance_sequencer(input logic func, input t_pattern sel);
        logic    busy;
        t_result lv;
        busy = (beep_phase == PH_ON) || (beep_phase == PH_SILENT);
        if (func == FUNC_REQUEST) begin
            if (!busy || rank[sel] > rank[cur_pat]) begin
                if (busy) n_restarts++;
                cur_pat    = sel;
                beeps_left = beep_total[sel];
                beep_phase = PH_ON;
                beep_ticks = '0;
            end
        end else if (busy) begin
            if (beep_ticks != '1) beep_ticks = beep_ticks + 1'b1;
            if (beep_phase == PH_ON) begin
                if (beep_ticks >= on_time[cur_pat]) begin
                    if (beeps_left != '0) beeps_left = beeps_left - 1'b1;
                    if (beeps_left != '0 && gap_ticks[cur_pat] != '0) begin
                        beep_phase = PH_SILENT;
                        beep_ticks = '0;
                    end else begin
                        beep_phase = PH_IDLE;
                    end
                end
            end else if (beep_ticks >= gap_ticks[cur_pat]) begin
                beep_phase = PH_ON;
                beep_ticks = '0;
                n_rebeeps++;
            end
        end
        lv.buzzer_on = (beep_phase == PH_ON);
        lv.busy_res  = (beep_phase != PH_IDLE);
        expected_levels.push_back(lv);
    endtask

    // valid stays high between back-to-back words
    task automatic send_word(input logic func, input t_pattern sel);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, sel};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        advance_sequencer(func, sel);
        n_words++;
    endtask

    task automatic send_tick();
        send_word(FUNC_TICK, rand_pat());
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
    endtask

    task automatic apb_read(input t_reg_idx idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        val = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] exp_v);
        logic [31:0] got;
        apb_read(idx, got);
        if (got !== exp_v) report_mismatch($sformatf("readback of register %s",
                                                     idx.name()), exp_v, got);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        logic [2:0] k;
        k = idx;
        apb_write(idx, val);
        n_reg_writes++;
        if (idx < REG_BRIEF_PRIO) begin
            on_time[k[1:0]] = val[TICK_W-1:0];
            check_reg(idx, {16'b0, val[TICK_W-1:0]});
        end else begin
            rank[k[1:0]] = val[PRIO_W-1:0];
            check_reg(idx, {28'b0, val[PRIO_W-1:0]});
        end
    endtask

    task automatic test_reset_values();
        quiesce();
        for (int k = 0; k < NUM_PAT; k++) begin
            check_reg(t_reg_idx'(k), {16'b0, on_time[k]});
            check_reg(t_reg_idx'(k + NUM_PAT), {28'b0, rank[k]});
        end
        apb_release();
    endtask

    task automatic test_directed();
        quiesce();
        write_reg(REG_BRIEF_ON, 32'd0);
        write_reg(REG_CONFIRM_ON, 32'd1);
        write_reg(REG_WARNING_ON, 32'd2);
        write_reg(REG_ALERT_ON, 32'd3);
        write_reg(REG_BRIEF_PRIO, 32'd0);
        write_reg(REG_CONFIRM_PRIO, 32'd0);
        write_reg(REG_WARNING_PRIO, 32'd7);
        write_reg(REG_ALERT_PRIO, 32'd15);
        apb_release();
        send_word(FUNC_TICK, PAT_ALERT);         // tick while idle
        send_word(FUNC_REQUEST, PAT_BRIEF);      // zero on time
        send_tick();
        send_word(FUNC_REQUEST, PAT_CONFIRM);
        send_word(FUNC_REQUEST, PAT_BRIEF);      // equal rank, ignored
        send_word(FUNC_REQUEST, PAT_CONFIRM);    // same pattern, ignored
        send_tick();
        send_word(FUNC_REQUEST, PAT_BRIEF);
        send_word(FUNC_REQUEST, PAT_WARNING);    // preempts
        send_word(FUNC_REQUEST, PAT_CONFIRM);    // lower, ignored
        send_tick();
        send_tick();                             // into silence
        send_word(FUNC_REQUEST, PAT_WARNING);
        send_word(FUNC_REQUEST, PAT_ALERT);      // preempts during silence
        send_word(FUNC_REQUEST, PAT_BRIEF);
        // rank of the playing pattern changes under it
        quiesce();
        write_reg(REG_ALERT_PRIO, 32'd0);
        write_reg(REG_BRIEF_PRIO, 32'd1);
        apb_release();
        send_word(FUNC_REQUEST, PAT_BRIEF);
        send_tick();
        send_word(FUNC_REQUEST, PAT_ALERT);
        send_word(FUNC_REQUEST, PAT_CONFIRM);
        // brief now outranks the alert, and its zero on time ends it at once
        send_word(FUNC_REQUEST, PAT_BRIEF);
        send_tick();
    endtask

    // full multi-beep runs, with preemption out of a silence
    task automatic test_full_patterns();
        idle_pct  = 17;
        stall_pct = 17;
        while (beep_phase != PH_IDLE) send_tick();
        quiesce();
        write_reg(REG_WARNING_ON, 32'd1);
        write_reg(REG_WARNING_PRIO, 32'd3);
        write_reg(REG_ALERT_PRIO, 32'd4);
        apb_release();
        send_word(FUNC_REQUEST, PAT_WARNING);
        repeat (10) send_tick();
        send_word(FUNC_REQUEST, PAT_ALERT);
        while (beep_phase != PH_IDLE) send_tick();
    endtask

    task automatic test_longest_beep();
        idle_pct  = 0;
        stall_pct = 0;
        quiesce();
        write_reg(REG_BRIEF_ON, 32'hFFFF);
        apb_release();
        send_word(FUNC_REQUEST, PAT_BRIEF);
        repeat (20) send_tick();
        // a shorter on time under the playing beep ends it on the next tick
        quiesce();
        write_reg(REG_BRIEF_ON, 32'd5);
        apb_release();
        while (beep_phase != PH_IDLE) send_tick();
    endtask

    task automatic test_random(input int snd_idle, input int rcv_stall);
        int          sent;
        int          burst;
        logic [31:0] val;
        idle_pct  = snd_idle;
        stall_pct = rcv_stall;
        quiesce();
        for (int k = 0; k < 2 * NUM_PAT; k++) begin
            case ($urandom_range(0, 3))
                0:       val = 32'd0;
                1:       val = (k < NUM_PAT) ? 32'd1 : 32'd15;
                default: val = (k < NUM_PAT) ? $urandom_range(1, 6) : $urandom_range(0, 15);
            endcase
            write_reg(t_reg_idx'(k), val);
        end
        apb_release();
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(1'($urandom_range(0, 1)), rand_pat());
                sent++;
            end else begin
                send_word(FUNC_REQUEST, rand_pat());
                sent++;
                burst = ($urandom_range(0, 3) == 0) ? 700 : $urandom_range(0, 12);
                while (burst > 0 && sent < RANDOM_WORDS && beep_phase != PH_IDLE) begin
                    if ($urandom_range(0, 19) == 0) send_word(FUNC_REQUEST, rand_pat());
                    else send_tick();
                    sent++;
                    burst--;
                end
            end
        end
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result word with nothing expected", 32'd0, 32'(m_tdata));
            end else begin
                level_due = expected_levels.pop_front();
                if (m_tdata[BUZZER_BIT] !== level_due.buzzer_on)
                    report_mismatch("buzzer_on", 32'(level_due.buzzer_on),
                                    32'(m_tdata[BUZZER_BIT]));
                if (m_tdata[BUSY_BIT] !== level_due.busy_res)
                    report_mismatch("busy_res", 32'(level_due.busy_res),
                                    32'(m_tdata[BUSY_BIT]));
            end
            n_results++;
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_full_patterns();
        test_longest_beep();
        test_random(0, 0);
        test_random(58, 0);
        test_random(0, 58);
        test_random(17, 17);
        quiesce();
        if (expected_levels.size() != 0)
            report_mismatch("results never delivered", 32'd0,
                            32'(expected_levels.size()));
        $display("%0d words in, %0d results checked, %0d preemptions, %0d repeat beeps",
                 n_words, n_results, n_restarts, n_rebeeps);
        $display("%0d register writes over four idling profiles, %0d mismatches",
                 n_reg_writes, n_mismatch);
        if (n_mismatch == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pbps_pkg.sv
rtl/pbps_cfg_regs.sv
rtl/pbps_core.sv
rtl/priority_beep_pattern_sequencer_unit.sv
rtl/pbps_checker.sv
test/tb_priority_beep_pattern_sequencer_unit.sv
